// ===== rtl/glyph_cache_tag_lookup_top_assert.svh =====
// assertion helpers for the glyph cache tag engine
`ifndef GLYPH_CACHE_TAG_LOOKUP_TOP_ASSERT_SVH
`define GLYPH_CACHE_TAG_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GCTL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gctl check failed");

// next-cycle implication, checked out of reset
`define GCTL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gctl check failed");

`endif

// ===== rtl/gctl_pkg.sv =====
`default_nettype none

package gctl_pkg;

    localparam int SLOTS_DEF       = 2048;
    localparam int PROBE_LIMIT_DEF = 8;

    localparam int FONT_W    = 1;
    localparam int GLYPH_W   = 16;
    localparam int SIZE_W    = 8;
    localparam int SLOT_W    = 11;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 4;
    localparam int HASH_W    = 32;
    localparam int SMALL_W   = 16;

    localparam logic [HASH_W-1:0]  GLYPH_MUL = 32'd2654435761;
    localparam logic [SMALL_W-1:0] FONT_MUL  = 16'd131;
    localparam logic [SMALL_W-1:0] SIZE_MUL  = 16'd97;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // packed so that the bits form the 25-bit tag directly
    typedef struct packed {
        logic [FONT_W-1:0]  font_index;
        logic [GLYPH_W-1:0] glyph_id;
        logic [SIZE_W-1:0]  pixel_size;
    } t_lookup_req;

    typedef struct packed {
        logic        valid;
        t_lookup_req tag;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/gctl_store.sv =====
`default_nettype none

module gctl_store
    import gctl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(SLOTS)-1:0] i_rd_addr,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  wire t_entry                   i_wr_data,
    output t_entry                        o_rd_data
);

    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/gctl_hash.sv =====
`default_nettype none

module gctl_hash
    import gctl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire t_lookup_req              i_req,
    output logic                          o_done,
    output logic [$clog2(SLOTS)-1:0]      o_home
);

    localparam int  ADDR_W  = $clog2(SLOTS);
    localparam int  BIT_W   = $clog2(HASH_W);
    localparam bit  IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_SUM  = 2'd1;
    localparam logic [1:0] H_RED  = 2'd2;

    logic [1:0]         r_state;
    logic               r_done;
    logic [HASH_W-1:0]  r_prod;
    logic [SMALL_W-1:0] r_small;
    logic [HASH_W-1:0]  r_hash;
    logic [ADDR_W-1:0]  r_rem;
    logic [BIT_W-1:0]   r_bit;
    logic [ADDR_W-1:0]  r_home;

    logic [HASH_W-1:0]  hash_sum;
    logic [ADDR_W:0]    rem_shift;
    logic [ADDR_W:0]    n_rem;

    assign hash_sum  = r_prod + HASH_W'(r_small);
    // restoring reduction, one hash bit a cycle, for slot counts that are not powers of two
    assign rem_shift = {r_rem, r_hash[HASH_W-1]};
    assign n_rem     = (rem_shift >= (ADDR_W+1)'(SLOTS)) ? rem_shift - (ADDR_W+1)'(SLOTS)
                                                        : rem_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_prod  <= HASH_W'({16'b0, i_req.glyph_id} * GLYPH_MUL);
                        r_small <= SMALL_W'(SMALL_W'(i_req.font_index) * FONT_MUL
                                          + SMALL_W'(i_req.pixel_size) * SIZE_MUL);
                        r_state <= H_SUM;
                    end
                end
                H_SUM: begin
                    if (IS_POW2) begin
                        r_home  <= hash_sum[ADDR_W-1:0];
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_hash  <= hash_sum;
                        r_rem   <= '0;
                        r_bit   <= '1;
                        r_state <= H_RED;
                    end
                end
                H_RED: begin
                    r_hash <= r_hash << 1;
                    r_rem  <= n_rem[ADDR_W-1:0];
                    r_bit  <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_home  <= n_rem[ADDR_W-1:0];
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

`default_nettype wire

// ===== rtl/glyph_cache_tag_lookup_top.sv =====
// sequence: input transfer, hash to the home slot, then p = 1..PROBE_LIMIT probes (one slot
//   read a cycle through the tag store's single read port), a tag write on a fill or an
//   eviction, then the result; hashing reduces bit-serially when SLOTS is not a power of two
// flow: one request at a time; the input stalls until the result is registered
// reset: clears the valid bit of every slot, one slot a cycle, with the input stalled
`default_nettype none

`include "glyph_cache_tag_lookup_top_assert.svh"

module glyph_cache_tag_lookup_top
    import gctl_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [FONT_W-1:0]    i_font_index,
    input  wire logic [GLYPH_W-1:0]   i_glyph_id,
    input  wire logic [SIZE_W-1:0]    i_pixel_size,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [SLOT_W-1:0]         o_slot,
    output logic [OUTCOME_W-1:0]      o_outcome,
    output logic [COUNT_W-1:0]        o_probe_count
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int PCNT_W = $clog2(PROBE_LIMIT + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           r_state;
    logic [ADDR_W-1:0]    r_paddr;
    logic [ADDR_W-1:0]    r_rd_slot;
    logic                 r_pend;
    logic [PCNT_W-1:0]    r_pcnt;
    logic [ADDR_W-1:0]    r_home;
    logic [ADDR_W-1:0]    r_chosen;
    t_lookup_req          r_tag;
    logic [OUTCOME_W-1:0] r_outcome;
    logic [PCNT_W-1:0]    r_count;
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_o_slot;
    logic [OUTCOME_W-1:0] r_o_outcome;
    logic [COUNT_W-1:0]   r_o_count;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 hash_done;
    logic [ADDR_W-1:0]    hash_home;
    logic                 mem_rd_en;
    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_wr_addr;
    t_entry               mem_wr_data;
    t_entry               rd_entry;
    logic                 probe_hit;
    logic                 probe_empty;
    logic [ADDR_W-1:0]    n_paddr;
    t_lookup_req          in_req;

    assign in_req   = '{font_index: i_font_index, glyph_id: i_glyph_id,
                        pixel_size: i_pixel_size};
    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    assign n_paddr = (r_paddr == ADDR_W'(SLOTS - 1)) ? '0 : r_paddr + 1'b1;

    assign probe_hit   = r_pend && rd_entry.valid && (rd_entry.tag == r_tag);
    assign probe_empty = r_pend && !rd_entry.valid;

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_chosen;
        mem_wr_data = '{valid: 1'b1, tag: r_tag};
        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_paddr;
                mem_wr_data = '0;
            end
            S_PROBE: mem_rd_en = 1'b1;
            S_WRITE: mem_wr_en = 1'b1;
            default: mem_rd_en = 1'b0;
        endcase
    end

    gctl_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_req   (in_req),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    gctl_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_paddr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_paddr     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the result load in S_DONE covers a transfer in the same cycle
            if (out_xfer && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_paddr <= n_paddr;
                    if (r_paddr == ADDR_W'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_tag   <= in_req;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_home  <= hash_home;
                        r_paddr <= hash_home;
                        r_pend  <= 1'b0;
                        r_pcnt  <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // read of the next slot overlaps the check of the previous one
                    r_paddr   <= n_paddr;
                    r_rd_slot <= r_paddr;
                    r_pend    <= 1'b1;
                    if (probe_hit) begin
                        r_chosen  <= r_rd_slot;
                        r_outcome <= OUT_HIT;
                        r_count   <= r_pcnt;
                        r_state   <= S_DONE;
                    end else if (probe_empty) begin
                        r_chosen  <= r_rd_slot;
                        r_outcome <= OUT_FILL;
                        r_count   <= r_pcnt;
                        r_state   <= S_WRITE;
                    end else if (r_pend) begin
                        if (r_pcnt == PCNT_W'(PROBE_LIMIT - 1)) begin
                            r_chosen  <= r_home;
                            r_outcome <= OUT_EVICT;
                            r_count   <= PCNT_W'(PROBE_LIMIT);
                            r_state   <= S_WRITE;
                        end else begin
                            r_pcnt <= r_pcnt + 1'b1;
                        end
                    end
                end
                S_WRITE: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_slot    <= SLOT_W'(r_chosen);
                        r_o_outcome <= r_outcome;
                        r_o_count   <= COUNT_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_slot        = r_o_slot;
    assign o_outcome     = r_o_outcome;
    assign o_probe_count = r_o_count;

    `GCTL_ASSERT_IMP(a_hash_done_in_hash, hash_done, r_state == S_HASH)
    `GCTL_ASSERT_NXT(a_hit_goes_done, (r_state == S_PROBE) && probe_hit,
                     (r_state == S_DONE) && (r_outcome == OUT_HIT))
    `GCTL_ASSERT_IMP(a_no_write_on_hit, r_state == S_WRITE, r_outcome != OUT_HIT)
    `GCTL_ASSERT_IMP(a_evict_count, r_out_valid && (r_o_outcome == OUT_EVICT),
                     r_o_count == COUNT_W'(PROBE_LIMIT))

endmodule

`default_nettype wire
